// ===== rtl/jsu_pkg.sv =====
// ============================================================================
// jsu_pkg: shared types and constants of the Jacobi symbol unit
// Holds the channel field widths, the result codes and the sequencer states.
// ============================================================================
package jsu_pkg;

	// Width of the operand fields on the input channel.
	localparam int unsigned FIELD_W = 64;

	// Two's complement codes of the symbol field.
	localparam logic signed [1:0] SYM_ZERO = 2'sb00;
	localparam logic signed [1:0] SYM_POS  = 2'sb01;
	localparam logic signed [1:0] SYM_NEG  = 2'sb11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_TEST,
		ST_FINISH
	} jsu_state_t;

	// Handshake between the sequencer and the shared remainder unit.
	typedef struct packed {
		logic start;
	} jsu_rem_req_t;

	typedef struct packed {
		logic done;
	} jsu_rem_rsp_t;

endpackage

// ===== rtl/jsu_stream_if.sv =====
// ============================================================================
// jsu_stream_if: valid/ready channels of the Jacobi symbol unit
// One interface for the operand channel and one for the result channel.
// ============================================================================
interface jsu_in_if import jsu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] value_n;
	logic [FIELD_W-1:0] modulus_p;

	modport source (output valid, output value_n, output modulus_p, input ready);
	modport sink   (input valid, input value_n, input modulus_p, output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [1:0] symbol;
	logic              zero_modulus_error;

	modport source (output valid, output symbol, output zero_modulus_error, input ready);
	modport sink   (input valid, input symbol, input zero_modulus_error, output ready);
endinterface

// ===== rtl/jsu_rem_unit.sv =====
// ============================================================================
// jsu_rem_unit: bit-serial remainder unit
// Restoring division that brings in one dividend bit per cycle and keeps only
// the remainder. The divisor must be nonzero.
// ============================================================================
module jsu_rem_unit import jsu_pkg::*; #(
	parameter int unsigned WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  jsu_rem_req_t     req,
	output jsu_rem_rsp_t     rsp,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] remainder
);

	localparam int unsigned CNT_W = $clog2(WIDTH);

	logic             running_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] div_bits_q;
	logic [WIDTH-1:0] divisor_q;
	logic [WIDTH-1:0] rem_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] rem_next;

	// One step: shift the next dividend bit in and subtract when it fits.
	always_comb begin
		trial = {rem_q, div_bits_q[WIDTH-1]};
		diff  = trial - {1'b0, divisor_q};
		if (trial >= {1'b0, divisor_q}) begin
			rem_next = diff[WIDTH-1:0];
		end else begin
			rem_next = trial[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				running_q <= 1'b1;
				cnt_q     <= CNT_W'(WIDTH - 1);
			end else if (running_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_bits_q <= dividend;
			divisor_q  <= divisor;
			rem_q      <= '0;
		end else if (running_q) begin
			div_bits_q <= {div_bits_q[WIDTH-2:0], 1'b0};
			rem_q      <= rem_next;
		end
	end

	assign rsp.done  = done_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/jacobi_symbol_unit.sv =====
// ============================================================================
// jacobi_symbol_unit: Jacobi symbol (n / p) by the binary algorithm
// Reduces n modulo p and iterates halving and swap-and-reduce steps on a
// single shared bit-serial remainder unit under a small sequencer.
// ============================================================================
//
// Channel    Role   Payload
// ---------  -----  -----------------------------------------------
// operands   sink   value_n[63:0], modulus_p[63:0]
// result     source symbol[1:0] (signed), zero_modulus_error
//
// Every reduction runs in the shared remainder unit, and each factor of two
// taken out of the running value is one halving step in the sequencer; how
// long an item takes is set by the number of swap-and-reduce rounds, and a
// zero modulus goes straight to the result. One item is in work at a time: the
// operand channel is ready only while the sequencer idles. A finished result
// sits in an output register, so a new operand transfer is taken while it
// waits; the next result is held back until that register has drained.
// Reset clears sequencer, output valid flag and remainder unit control only.
//
module jacobi_symbol_unit import jsu_pkg::*; #(
	parameter int unsigned WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	jsu_in_if.sink     operands,
	jsu_out_if.source  result
);

	jsu_state_t state_q;
	jsu_state_t state_next;

	// Running value, running modulus and accumulated sign (1 means negative).
	logic [WIDTH-1:0] r_q;
	logic [WIDTH-1:0] m_q;
	logic             neg_q;
	logic             err_q;

	logic              out_valid_q;
	logic signed [1:0] out_symbol_q;
	logic              out_err_q;

	jsu_rem_req_t     rem_req;
	jsu_rem_rsp_t     rem_rsp;
	logic [WIDTH-1:0] rem_dividend;
	logic [WIDTH-1:0] rem_divisor;
	logic [WIDTH-1:0] rem_value;

	logic             in_xfer;
	logic             out_free;
	logic             load_out;
	logic [WIDTH-1:0] n_in;
	logic [WIDTH-1:0] p_in;
	logic             r_zero;
	logic             flip_half;
	logic             flip_swap;
	logic signed [1:0] final_symbol;

	// Operands beyond WIDTH bits are dropped on entry.
	assign n_in = operands.value_n[WIDTH-1:0];
	assign p_in = operands.modulus_p[WIDTH-1:0];

	assign in_xfer  = operands.valid && operands.ready;
	assign out_free = !out_valid_q || result.ready;
	assign r_zero   = (r_q == '0);

	// Halving flips the sign when the modulus is 3 or 5 mod 8; a swap flips it
	// when both values are 3 mod 4.
	assign flip_half = (m_q[2:0] == 3'd3) || (m_q[2:0] == 3'd5);
	assign flip_swap = (r_q[1:0] == 2'd3) && (m_q[1:0] == 2'd3);

	always_comb begin
		if (err_q || (m_q != WIDTH'(1))) begin
			final_symbol = SYM_ZERO;
		end else if (neg_q) begin
			final_symbol = SYM_NEG;
		end else begin
			final_symbol = SYM_POS;
		end
	end

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (p_in == '0) begin
						state_next = ST_FINISH;
					end else begin
						state_next = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (rem_rsp.done) begin
					state_next = ST_TEST;
				end
			end
			ST_TEST: begin
				if (r_zero) begin
					state_next = ST_FINISH;
				end else if (r_q[0]) begin
					state_next = ST_REDUCE;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		operands.ready = 1'b0;
		rem_req.start  = 1'b0;
		rem_dividend   = m_q;
		rem_divisor    = r_q;
		load_out       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				operands.ready = 1'b1;
				rem_req.start  = operands.valid && (p_in != '0);
				rem_dividend   = n_in;
				rem_divisor    = p_in;
			end
			ST_TEST: begin
				// An odd nonzero value swaps places with the modulus and the old
				// modulus is reduced by it.
				rem_req.start = !r_zero && r_q[0];
			end
			ST_FINISH: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the iteration.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					m_q   <= p_in;
					neg_q <= 1'b0;
					err_q <= (p_in == '0);
				end
			end
			ST_REDUCE: begin
				if (rem_rsp.done) begin
					r_q <= rem_value;
				end
			end
			ST_TEST: begin
				if (!r_zero) begin
					if (!r_q[0]) begin
						r_q   <= {1'b0, r_q[WIDTH-1:1]};
						neg_q <= neg_q ^ flip_half;
					end else begin
						m_q   <= r_q;
						neg_q <= neg_q ^ flip_swap;
					end
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_symbol_q <= final_symbol;
			out_err_q    <= err_q;
		end
	end

	jsu_rem_unit #(
		.WIDTH (WIDTH)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (rem_req),
		.rsp       (rem_rsp),
		.dividend  (rem_dividend),
		.divisor   (rem_divisor),
		.remainder (rem_value)
	);

	assign result.valid              = out_valid_q;
	assign result.symbol             = out_symbol_q;
	assign result.zero_modulus_error = out_err_q;

endmodule
